// ===== rtl/core/stwb_pkg.sv =====
// ----------------------------------------------------------------------------
// stwb_pkg
// Shared types and constants of the stopwatch timer bank: request and
// response payloads, time values and the per-channel state entry.
// ----------------------------------------------------------------------------
package stwb_pkg;

   localparam int unsigned CHANNELS_DEF = 8;
   localparam int unsigned SEC_W        = 32;
   localparam int unsigned USEC_W       = 20;
   localparam int unsigned CH_W         = 8;

   localparam logic [USEC_W-1:0] USEC_PER_SEC = USEC_W'(1000000);

   typedef enum logic [1:0] {
      CMD_START = 2'd0,
      CMD_STOP  = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_READ  = 2'd3
   } cmd_type;

   typedef struct packed {
      logic [SEC_W-1:0]  sec;
      logic [USEC_W-1:0] usec;
   } tval_type;

   typedef struct packed {
      logic [1:0]        cmd;
      logic [CH_W-1:0]   channel;
      logic [SEC_W-1:0]  wall_now_sec;
      logic [USEC_W-1:0] wall_now_usec;
      logic [SEC_W-1:0]  cpu_now_sec;
      logic [USEC_W-1:0] cpu_now_usec;
   } req_type;

   typedef struct packed {
      logic                    status;
      logic [SEC_W-1:0]        wall_total_sec;
      logic [USEC_W-1:0]       wall_total_usec;
      logic [SEC_W-1:0]        busy_total_sec;
      logic [USEC_W-1:0]       busy_total_usec;
      logic signed [SEC_W-1:0] idle_total_sec;
      logic [USEC_W-1:0]       idle_total_usec;
   } rsp_type;

   typedef struct packed {
      logic     running;
      tval_type start_wall;
      tval_type start_cpu;
      tval_type acc_wall;
      tval_type acc_cpu;
   } entry_type;

endpackage

// ===== rtl/core/stopwatch_timer_bank_unit.sv =====
// ----------------------------------------------------------------------------
// stopwatch_timer_bank_unit
// Bank of stopwatch channels with wall and processor time accumulators.
// ----------------------------------------------------------------------------
// A request names a 1-based channel and a command (start, stop, clear, read)
// and carries the current wall and processor time samples. Each request gives
// exactly one response with a status bit and the channel's wall, busy and
// idle totals after the command; a bad channel returns status 1 and zeros.
// Channel state sits in one memory of CHANNELS entries, read at the edge that
// takes the request, updated in ST_DIFF and ST_SUM and written back from ST_SUM.
// A request runs through the read, the two accumulate steps (ST_DIFF, ST_SUM)
// and the idle subtraction in ST_FIN, where the response is registered; one
// request is in work at a time, none is taken while it runs. A new request is taken as
// soon as the previous one has moved into the response register.
// Reset clears the control state and the per-entry valid bits; an entry never
// written reads as all zero. No clearing pass is needed.
// When the receiver stalls, the response register holds; a finished request
// then waits in the last step until the register frees up.
// ----------------------------------------------------------------------------
module stopwatch_timer_bank_unit
   import stwb_pkg::*;
#(
   parameter int unsigned CHANNELS = CHANNELS_DEF
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int unsigned AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   typedef enum logic [3:0] {
      ST_WAIT = 4'b0001,
      ST_DIFF = 4'b0010,
      ST_SUM  = 4'b0100,
      ST_FIN  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   entry_type mem [CHANNELS];

   logic [CHANNELS-1:0] valid_ff, valid_in;
   req_type             req_ff;
   logic                ch_ok_ff;
   logic [AW-1:0]       addr_ff;
   entry_type           rd_ff;
   logic                rd_valid_ff;
   logic                status_ff;
   tval_type            wall_tot_ff;
   tval_type            busy_tot_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic            accept;
   logic            ch_ok;
   logic [CH_W-1:0] ch_m1;
   logic [AW-1:0]   addr;
   entry_type       entry;
   entry_type       wr_entry;
   logic            mem_we;
   logic            stop_err;
   tval_type        wall_new;
   tval_type        busy_new;
   logic            out_free;

   logic signed [USEC_W:0] idle_us0;
   logic [USEC_W:0]        idle_us1;
   logic [SEC_W-1:0]       idle_sec;

   assign req_ready = (state_ff == ST_WAIT);
   assign accept    = req_valid && req_ready;
   assign ch_ok     = (req_data.channel != '0) && (32'(req_data.channel) <= CHANNELS);
   assign ch_m1     = req_data.channel - CH_W'(1);
   assign addr      = ch_m1[AW-1:0];
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // an entry never written reads as reset state
   assign entry = rd_valid_ff ? rd_ff : '0;

   stwb_elapsed u_wall (
      .clock    (clock),
      .load     (state_ff == ST_DIFF),
      .now_val  ({req_ff.wall_now_sec, req_ff.wall_now_usec}),
      .then_val (entry.start_wall),
      .acc_val  (entry.acc_wall),
      .total    (wall_new)
   );

   stwb_elapsed u_cpu (
      .clock    (clock),
      .load     (state_ff == ST_DIFF),
      .now_val  ({req_ff.cpu_now_sec, req_ff.cpu_now_usec}),
      .then_val (entry.start_cpu),
      .acc_val  (entry.acc_cpu),
      .total    (busy_new)
   );

   always_comb begin
      wr_entry = entry;
      stop_err = 1'b0;
      unique case (req_ff.cmd)
         CMD_START: begin
            wr_entry.running    = 1'b1;
            wr_entry.start_wall = {req_ff.wall_now_sec, req_ff.wall_now_usec};
            wr_entry.start_cpu  = {req_ff.cpu_now_sec, req_ff.cpu_now_usec};
         end
         CMD_STOP: begin
            if (entry.running) begin
               wr_entry.running  = 1'b0;
               wr_entry.acc_wall = wall_new;
               wr_entry.acc_cpu  = busy_new;
            end else begin
               stop_err = 1'b1;
            end
         end
         CMD_CLEAR: begin
            wr_entry.running  = 1'b0;
            wr_entry.acc_wall = '0;
            wr_entry.acc_cpu  = '0;
         end
         CMD_READ: begin
            wr_entry = entry;
         end
         default: begin
            wr_entry = entry;
         end
      endcase
   end

   assign mem_we = (state_ff == ST_SUM) && ch_ok_ff && (req_ff.cmd != CMD_READ);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[addr_ff] <= wr_entry;
      end
      if (accept) begin
         rd_ff <= mem[addr];
      end
   end

   // idle time from the registered totals, one borrow at most
   always_comb begin
      idle_us0 = $signed({1'b0, wall_tot_ff.usec}) - $signed({1'b0, busy_tot_ff.usec});
      idle_sec = wall_tot_ff.sec - busy_tot_ff.sec;
      idle_us1 = idle_us0;
      if (idle_us0[USEC_W]) begin
         idle_us1 = idle_us0 + $signed({1'b0, USEC_PER_SEC});
         idle_sec = idle_sec - SEC_W'(1);
      end
   end

   always_comb begin
      rsp_in = '0;
      if (ch_ok_ff) begin
         rsp_in.status          = status_ff;
         rsp_in.wall_total_sec  = wall_tot_ff.sec;
         rsp_in.wall_total_usec = wall_tot_ff.usec;
         rsp_in.busy_total_sec  = busy_tot_ff.sec;
         rsp_in.busy_total_usec = busy_tot_ff.usec;
         rsp_in.idle_total_sec  = $signed(idle_sec);
         rsp_in.idle_total_usec = idle_us1[USEC_W-1:0];
      end else begin
         rsp_in.status = 1'b1;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      valid_in     = valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (mem_we) begin
         valid_in[addr_ff] = 1'b1;
      end
      unique case (state_ff)
         ST_WAIT: begin
            if (accept) begin
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            state_in = ST_SUM;
         end
         ST_SUM: begin
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_WAIT;
            end
         end
         default: begin
            state_in = ST_WAIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_WAIT;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff      <= req_data;
         ch_ok_ff    <= ch_ok;
         addr_ff     <= addr;
         rd_valid_ff <= valid_ff[addr];
      end
      if (state_ff == ST_SUM) begin
         status_ff   <= stop_err;
         wall_tot_ff <= wr_entry.acc_wall;
         busy_tot_ff <= wr_entry.acc_cpu;
      end
      if ((state_ff == ST_FIN) && out_free) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== rtl/core/stwb_elapsed.sv =====
// ----------------------------------------------------------------------------
// stwb_elapsed
// Adds an elapsed interval (now minus then) to an accumulated time value in
// two steps: a registered difference with microsecond borrow, then the sum
// with microsecond carry and the seconds correction.
// ----------------------------------------------------------------------------
module stwb_elapsed
   import stwb_pkg::*;
(
   input  logic     clock,
   input  logic     load,
   input  tval_type now_val,
   input  tval_type then_val,
   input  tval_type acc_val,
   output tval_type total
);

   localparam int unsigned DIFF_W = USEC_W + 2;
   localparam int unsigned SUM_W  = USEC_W + 1;

   logic signed [DIFF_W-1:0] diff0;
   logic signed [DIFF_W-1:0] diff1;
   logic signed [DIFF_W-1:0] diff2;
   logic                     borrow1;
   logic                     borrow2;

   logic [USEC_W-1:0] diff_ff, diff_in;
   logic [1:0]        borrow_ff, borrow_in;
   logic [SEC_W-1:0]  sec_diff_ff, sec_diff_in;

   logic [SUM_W-1:0]  sum0;
   logic [SUM_W-1:0]  sum1;
   logic [SUM_W-1:0]  sum2;
   logic              carry1;
   logic              carry2;
   logic [1:0]        carry;
   logic [SEC_W-1:0]  adj;

   // unnormalized inputs can need up to two borrows
   always_comb begin
      diff0   = $signed({2'b00, now_val.usec}) - $signed({2'b00, then_val.usec});
      borrow1 = diff0[DIFF_W-1];
      diff1   = borrow1 ? diff0 + $signed({2'b00, USEC_PER_SEC}) : diff0;
      borrow2 = diff1[DIFF_W-1];
      diff2   = borrow2 ? diff1 + $signed({2'b00, USEC_PER_SEC}) : diff1;
      diff_in     = diff2[USEC_W-1:0];
      borrow_in   = {1'b0, borrow1} + {1'b0, borrow2};
      sec_diff_in = now_val.sec - then_val.sec;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         diff_ff     <= diff_in;
         borrow_ff   <= borrow_in;
         sec_diff_ff <= sec_diff_in;
      end
   end

   always_comb begin
      sum0   = {1'b0, acc_val.usec} + {1'b0, diff_ff};
      carry1 = (sum0 >= {1'b0, USEC_PER_SEC});
      sum1   = carry1 ? sum0 - {1'b0, USEC_PER_SEC} : sum0;
      carry2 = (sum1 >= {1'b0, USEC_PER_SEC});
      sum2   = carry2 ? sum1 - {1'b0, USEC_PER_SEC} : sum1;
      carry  = {1'b0, carry1} + {1'b0, carry2};
      adj    = {{(SEC_W-2){1'b0}}, carry} - {{(SEC_W-2){1'b0}}, borrow_ff};
      total.sec  = acc_val.sec + sec_diff_ff + adj;
      total.usec = sum2[USEC_W-1:0];
   end

endmodule
